### hw/rtl/fpqe_pkg.sv
// ----------------------------------------------------------------------------
// fpqe_pkg
// Shared types and codes for the FIFO / priority queue engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fpqe_pkg;

  // Opcodes
  localparam logic [2:0] OP_ENQ    = 3'd0;
  localparam logic [2:0] OP_DEQ    = 3'd1;
  localparam logic [2:0] OP_SEARCH = 3'd2;
  localparam logic [2:0] OP_SORT   = 3'd3;
  localparam logic [2:0] OP_REV    = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [15:0]        match_mask;
    logic [4:0]         match_count;
    logic [4:0]         occupancy;
  } out_t;

  // What every cell does on the coming edge
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_DEQ,
    CMD_INS,
    CMD_NET
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e cmd;
    logic      phase;  // parity of the low slot of each pair in a network round
    logic      rev;    // network round swaps unconditionally
  } cell_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/fpqe_cell.sv
// ----------------------------------------------------------------------------
// fpqe_cell
// One queue slot: shift, insert, compare-exchange with the next slot.
// ----------------------------------------------------------------------------
`default_nettype none

module fpqe_cell
  import fpqe_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5,
  parameter int IDX        = 0
) (
  input  wire logic                  clk_i,
  input  wire cell_ctrl_t            ctrl_i,
  input  wire logic [CNT_W-1:0]      cnt_i,
  input  wire logic [CNT_W-1:0]      pos_i,
  input  wire logic [DATA_WIDTH-1:0] val_i,
  input  wire logic [DATA_WIDTH-1:0] prev_i,
  input  wire logic [DATA_WIDTH-1:0] next_i,
  input  wire logic                  swap_i,
  output logic [DATA_WIDTH-1:0]      data_o,
  output logic                       gt_o,
  output logic                       eq_o,
  output logic                       swap_o
);

  localparam logic [CNT_W-1:0] MY_IDX   = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] NEXT_IDX = CNT_W'(IDX + 1);
  localparam logic             IDX_ODD  = 1'(IDX % 2);

  logic [DATA_WIDTH-1:0] slot_q, slot_d;
  logic                  pair_low;

  // key strictly greater than this slot, and equality, for the controller
  assign gt_o = $signed(val_i) > $signed(slot_q);
  assign eq_o = (val_i == slot_q);

  // low member of an active pair in this network round
  assign pair_low = (IDX_ODD == ctrl_i.phase) && (NEXT_IDX < cnt_i);
  assign swap_o   = pair_low && (ctrl_i.rev || ($signed(slot_q) > $signed(next_i)));

  always_comb begin
    slot_d = slot_q;
    case (ctrl_i.cmd)
      CMD_DEQ: begin
        if (NEXT_IDX < cnt_i) slot_d = next_i;
      end
      CMD_INS: begin
        if (MY_IDX == pos_i) begin
          slot_d = val_i;
        end else if ((MY_IDX > pos_i) && (MY_IDX <= cnt_i)) begin
          slot_d = prev_i;
        end
      end
      CMD_NET: begin
        if (swap_o) begin
          slot_d = next_i;
        end else if (swap_i) begin
          slot_d = prev_i;
        end
      end
      default: slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign data_o = slot_q;

endmodule

`default_nettype wire

### hw/rtl/fifo_priority_queue_engine_core.sv
// ----------------------------------------------------------------------------
// fifo_priority_queue_engine_core
// Bounded queue of signed entries in a row of slot cells, FIFO or priority.
// ----------------------------------------------------------------------------
// Sequence: each operation passes the accept (idle), compare and execute
//   states before its result is registered; sort and reverse of n entries
//   run n odd-even network rounds in execute, one round per cycle; execute
//   holds while the output register is full. One operation at a time: a
//   new beat is taken only back in idle, once the last result is registered.
// Reset: entry count, mode and control clear at once; slot data is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_priority_queue_engine_core
  import fpqe_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  // operation beats
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  // result beats
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o,
  // mode register write
  input  wire logic cfg_valid_i,
  output logic      cfg_ready_o,
  input  wire logic cfg_data_i
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // controller states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]            state_q, state_d;
  logic                  mode_q;
  logic [2:0]            op_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      round_q, round_d;
  logic [DEPTH-1:0]      gt_q, eq_q;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q, out_d;

  // cell row wiring
  logic [DATA_WIDTH-1:0] slot_w [DEPTH];
  logic [DEPTH-1:0]      gt_w, eq_w, swap_w;
  cell_ctrl_t            ctrl;
  logic [CNT_W-1:0]      ins_pos;

  logic                  in_beat, out_free;
  logic [63:0]           v64, rem64, mask64;
  logic [DEPTH-1:0]      occ, eq_m;
  logic [6:0]            pop;
  logic [7:0]            cnt8;

  assign in_beat  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // the 32-bit key is sign extended, then wrapped to the slot width
  assign v64 = 64'(in_data_i.value);

  // occupied slots
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      occ[k] = (CNT_W'(k) < cnt_q);
    end
  end

  // insert position: the tail in FIFO mode; in priority mode just past the last
  // held entry that is not smaller than the key (last hit of a head-first scan)
  always_comb begin
    ins_pos = '0;
    if (!mode_q) begin
      ins_pos = cnt_q;
    end else begin
      for (int k = 0; k < DEPTH; k++) begin
        if (occ[k] && !gt_q[k]) ins_pos = CNT_W'(k + 1);
      end
    end
  end

  // search results from the registered equality flags
  assign eq_m   = eq_q & occ;
  assign pop    = 7'($countones(eq_m));
  assign mask64 = 64'(eq_m);
  assign rem64  = 64'(slot_w[0]);

  // ---------------------------------------------------------------------
  // controller
  // ---------------------------------------------------------------------
  always_comb begin
    logic finish;
    logic act;
    logic [1:0] st;

    state_d     = state_q;
    cnt_d       = cnt_q;
    round_d     = round_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ctrl.cmd    = CMD_HOLD;
    ctrl.phase  = round_q[0];
    ctrl.rev    = (op_q == OP_REV);
    finish      = 1'b0;
    act         = 1'b0;
    st          = ST_OK;
    cnt8        = '0;

    case (state_q)
      S_IDLE: begin
        if (in_beat) state_d = S_CMP;
      end
      S_CMP: begin
        // flags land in gt_q / eq_q this edge
        round_d = '0;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        // fields that only some operations fill
        out_d.removed_value = '0;
        out_d.match_mask    = '0;
        out_d.match_count   = '0;

        case (op_q)
          OP_ENQ: begin
            finish = 1'b1;
            if (cnt_q >= FULL_CNT) begin
              st = ST_FULL;
            end else if (out_free) begin
              ctrl.cmd = CMD_INS;
              cnt_d    = cnt_q + 1'b1;
            end
          end
          OP_DEQ: begin
            finish = 1'b1;
            if (cnt_q == '0) begin
              st = ST_EMPTY;
            end else begin
              out_d.removed_value = rem64[31:0];
              if (out_free) begin
                ctrl.cmd = CMD_DEQ;
                cnt_d    = cnt_q - 1'b1;
              end
            end
          end
          OP_SEARCH: begin
            finish            = 1'b1;
            out_d.match_mask  = mask64[15:0];
            out_d.match_count = pop[4:0];
          end
          OP_SORT, OP_REV: begin
            if (mode_q) begin
              finish = 1'b1;
              st     = ST_REFUSED;
            end else if (cnt_q < CNT_W'(2)) begin
              finish = 1'b1;
            end else if (round_q == cnt_q - 1'b1) begin
              // last round waits for the output register
              finish = 1'b1;
              if (out_free) ctrl.cmd = CMD_NET;
            end else begin
              ctrl.cmd = CMD_NET;
              round_d  = round_q + 1'b1;
            end
          end
          default: finish = 1'b1;  // unused opcodes do nothing
        endcase

        act = finish && out_free;
        if (act) begin
          cnt8            = 8'(cnt_d);
          out_d.status    = st;
          out_d.occupancy = cnt8[4:0];
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end else begin
          out_d = out_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      round_q     <= '0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) mode_q <= cfg_data_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      op_q  <= in_data_i.opcode;
      val_q <= v64[DATA_WIDTH-1:0];
    end
    if (state_q == S_CMP) begin
      gt_q <= gt_w;
      eq_q <= eq_w;
    end
    out_q <= out_d;
  end

  // ---------------------------------------------------------------------
  // cell row, head at index 0
  // ---------------------------------------------------------------------
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev, next;
    logic                  swap_in;

    if (k == 0) begin : g_head
      assign prev    = '0;
      assign swap_in = 1'b0;
    end else begin : g_mid
      assign prev    = slot_w[k-1];
      assign swap_in = swap_w[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign next = '0;
    end else begin : g_body
      assign next = slot_w[k+1];
    end

    fpqe_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (k)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .cnt_i  (cnt_q),
      .pos_i  (ins_pos),
      .val_i  (val_q),
      .prev_i (prev),
      .next_i (next),
      .swap_i (swap_in),
      .data_o (slot_w[k]),
      .gt_o   (gt_w[k]),
      .eq_o   (eq_w[k]),
      .swap_o (swap_w[k])
    );
  end

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FIFO / priority queue engine: a scoreboard
// keeps its own copy of the queue, predicts one result per operation beat
// and checks every result beat field by field, with random idling on both
// channels and mode register writes between phases.
// ----------------------------------------------------------------------------

module tb_top;
  import fpqe_pkg::*;

  localparam int QDEPTH = 16;
  localparam int PHASES = 12;
  localparam int PHASE_OPS = 100;
  // opcodes the block has no use for; they still return a result
  localparam logic [2:0] OP_SPARE_LO = 3'd5;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow queue, mode bit and the results still owed
  // --------------------------------------------------------------------------
  class queue_scoreboard;
    logic signed [31:0] shadow_slot [QDEPTH];
    int unsigned        fill;
    logic               prio_mode;
    out_t               owed_q [$];
    int unsigned        errors;
    int unsigned        ops_seen;
    int unsigned        results_seen;
    int unsigned        full_hits;
    int unsigned        empty_hits;
    int unsigned        refused_hits;
    int unsigned        match_hits;

    function new();
      fill = 0;
      prio_mode = 1'b0;
      errors = 0;
      ops_seen = 0;
      results_seen = 0;
      full_hits = 0;
      empty_hits = 0;
      refused_hits = 0;
      match_hits = 0;
    endfunction

    function void set_mode(logic m);
      prio_mode = m;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Work out the result of one accepted operation beat and queue it
    function void note_op(in_t op);
      out_t               res;
      int                 i;
      int                 j;
      logic signed [31:0] v;
      logic signed [31:0] t;
      res = '0;
      res.status = ST_OK;
      v = op.value;
      ops_seen++;
      case (op.opcode)
        OP_ENQ: begin
          if (fill >= QDEPTH) begin
            res.status = ST_FULL;
            full_hits++;
          end else if (!prio_mode) begin
            shadow_slot[fill] = v;
            fill++;
          end else begin
            // scan from the tail; land after entries not smaller than v
            i = fill;
            while (i > 0 && v > shadow_slot[i-1]) begin
              shadow_slot[i] = shadow_slot[i-1];
              i--;
            end
            shadow_slot[i] = v;
            fill++;
          end
        end
        OP_DEQ: begin
          if (fill == 0) begin
            res.status = ST_EMPTY;
            empty_hits++;
          end else begin
            res.removed_value = shadow_slot[0];
            for (i = 0; i + 1 < fill; i++) shadow_slot[i] = shadow_slot[i+1];
            fill--;
          end
        end
        OP_SEARCH: begin
          for (i = 0; i < fill; i++) begin
            if (shadow_slot[i] == v) begin
              res.match_mask[i] = 1'b1;
              res.match_count = res.match_count + 5'd1;
            end
          end
          if (res.match_count != 0) match_hits++;
        end
        OP_SORT: begin
          if (prio_mode) begin
            res.status = ST_REFUSED;
            refused_hits++;
          end else begin
            for (i = 1; i < fill; i++) begin
              t = shadow_slot[i];
              j = i;
              while (j > 0 && shadow_slot[j-1] > t) begin
                shadow_slot[j] = shadow_slot[j-1];
                j--;
              end
              shadow_slot[j] = t;
            end
          end
        end
        OP_REV: begin
          if (prio_mode) begin
            res.status = ST_REFUSED;
            refused_hits++;
          end else begin
            for (i = 0; i < fill / 2; i++) begin
              t = shadow_slot[i];
              shadow_slot[i] = shadow_slot[fill-1-i];
              shadow_slot[fill-1-i] = t;
            end
          end
        end
        default: ;
      endcase
      res.occupancy = 5'(fill);
      owed_q.push_back(res);
    endfunction

    // Compare a result beat against the oldest owed result
    function void check_result(out_t got);
      out_t exp;
      results_seen++;
      if (owed_q.size() == 0) begin
        $error("result beat with nothing owed: %p", got);
        errors++;
        return;
      end
      exp = owed_q.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        errors++;
      end
      if (got.removed_value !== exp.removed_value) begin
        $error("removed_value: expected %0d, actual %0d",
               exp.removed_value, got.removed_value);
        errors++;
      end
      if (got.match_mask !== exp.match_mask) begin
        $error("match_mask: expected %h, actual %h", exp.match_mask, got.match_mask);
        errors++;
      end
      if (got.match_count !== exp.match_count) begin
        $error("match_count: expected %0d, actual %0d",
               exp.match_count, got.match_count);
        errors++;
      end
      if (got.occupancy !== exp.occupancy) begin
        $error("occupancy: expected %0d, actual %0d", exp.occupancy, got.occupancy);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_data_i = 1'b0;

  // random idling on both channels; cleared for one quiet phase
  bit gaps_on = 1'b1;

  queue_scoreboard sb;

  always #5 clk_i = ~clk_i;

  fifo_priority_queue_engine_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, and every accepted beat is checked.
  // Outputs are sampled right after the edge, i.e. the values the block
  // presented at that edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!gaps_on) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= 29);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // --------------------------------------------------------------------------
  // Operation side
  // --------------------------------------------------------------------------
  function automatic in_t mk_op(logic [2:0] opc, logic signed [31:0] val);
    in_t op;
    op.opcode = opc;
    op.value = val;
    return op;
  endfunction

  // One operation beat. Valid is left high on return so back-to-back beats
  // never drop it; anyone who stops sending lowers it first.
  task automatic push_op(input in_t op);
    while (gaps_on && $urandom_range(0, 99) < 29) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= op;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_op(op);
  endtask

  // Stop sending and wait until every owed result has come back
  task automatic wait_queue_settled();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Mode register beat, only with the block idle
  task automatic write_mode(input logic m);
    wait_queue_settled();
    // every operation returns a result, so a short pause covers any tail
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.set_mode(m);
  endtask

  // Small values give ties and search hits; extremes and full-range words
  // exercise every data bit and the signed ordering.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3:    return $urandom;
      default: return int'($urandom_range(0, 6)) - 3;
    endcase
  endfunction

  // Opcode mix; enq_pct sets whether a phase drifts toward full or empty
  function automatic in_t pick_op(int enq_pct);
    int          r;
    logic [2:0]  opc;
    r = $urandom_range(0, 99);
    if (r < enq_pct)                opc = OP_ENQ;
    else if (r < enq_pct + 15)      opc = OP_SEARCH;
    else if (r < 90)                opc = OP_DEQ;
    else if (r < 94)                opc = OP_SORT;
    else if (r < 98)                opc = OP_REV;
    else                            opc = OP_SPARE_LO + 3'($urandom_range(0, 2));
    return mk_op(opc, pick_value());
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int enq_pct;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: plain FIFO on an empty queue, then with a few entries
    write_mode(1'b0);
    push_op(mk_op(OP_DEQ, 32'sd0));          // dequeue when empty
    push_op(mk_op(OP_SEARCH, 32'sd0));       // search on empty queue
    push_op(mk_op(OP_SORT, 32'sd0));         // sort of nothing
    push_op(mk_op(OP_REV, 32'sd0));
    push_op(mk_op(OP_ENQ, 32'sh8000_0000));
    push_op(mk_op(OP_SORT, 32'sd0));         // single entry, no change
    push_op(mk_op(OP_REV, 32'sd0));
    push_op(mk_op(OP_ENQ, 32'sh7fff_ffff));
    push_op(mk_op(OP_ENQ, 32'sd0));
    push_op(mk_op(OP_ENQ, -32'sd1));
    push_op(mk_op(OP_ENQ, 32'sd0));
    push_op(mk_op(OP_SEARCH, 32'sd0));       // two hits
    push_op(mk_op(OP_SORT, 32'sd0));
    push_op(mk_op(OP_REV, 32'sd0));
    push_op(mk_op(OP_SPARE_LO, 32'sh7fff_ffff));
    push_op(mk_op(3'd7, -32'sd1));
    push_op(mk_op(OP_DEQ, 32'sd0));

    // priority mode switched on with entries held: contents stay as they are
    write_mode(1'b1);
    push_op(mk_op(OP_ENQ, 32'sd0));          // tie, lands after equals
    push_op(mk_op(OP_ENQ, 32'sh7fff_ffff));
    push_op(mk_op(OP_SORT, 32'sd0));         // refused
    push_op(mk_op(OP_REV, 32'sd0));          // refused
    push_op(mk_op(OP_SEARCH, 32'sd0));
    push_op(mk_op(OP_DEQ, 32'sd0));
    push_op(mk_op(3'd6, 32'sh8000_0000));

    // random phases; the queue is kept across phases so mode flips hit a
    // partly filled store. Each phase start drains the result side fully.
    for (int p = 0; p < PHASES; p++) begin
      if (p < 2) write_mode(p[0]);
      else write_mode(1'($urandom_range(0, 1)));
      case (p % 3)
        0:       enq_pct = 65;
        1:       enq_pct = 38;
        default: enq_pct = 20;
      endcase
      gaps_on = (p != 4);
      for (int k = 0; k < PHASE_OPS; k++) push_op(pick_op(enq_pct));
    end
    gaps_on = 1'b1;

    wait_queue_settled();
    // longest operation is a full-depth sort; leave room for stray beats
    repeat (4 * QDEPTH) @(posedge clk_i);

    $display("tb_top: %0d operations, %0d results compared in both modes",
             sb.ops_seen, sb.results_seen);
    $display("tb_top: full %0d, empty %0d, refused %0d, search hits %0d",
             sb.full_hits, sb.empty_hits, sb.refused_hits, sb.match_hits);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("tb_top: errors");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/fpqe_pkg.sv
hw/rtl/fpqe_cell.sv
hw/rtl/fifo_priority_queue_engine_core.sv
dv/tb_top.sv
